FILE: rtl/lkvc_pkg.sv
// Shared constants, request/response types and operation codes for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int RANK_W     = IDX_W;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 5;
    localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_GET      = 2'd1,
        OP_ERASE    = 2'd2,
        OP_CONTAINS = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               found;
        logic               status;
        logic [VALUE_W-1:0] read_value;
    } t_rsp;

endpackage

FILE: rtl/lkvc_core.sv
// Entry storage, parallel key match and recency-rank update of the LRU key-value cache.
module lkvc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  lkvc_pkg::t_req              i_req,
    input  logic [lkvc_pkg::CAP_W-1:0]  i_capacity,
    output lkvc_pkg::t_rsp              o_rsp
);
    import lkvc_pkg::*;

    logic [KEY_W-1:0]   r_key   [ENTRIES];
    logic [VALUE_W-1:0] r_value [ENTRIES];
    logic [RANK_W-1:0]  r_rank  [ENTRIES];
    logic [RANK_W-1:0]  n_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   n_used;

    logic [ENTRIES-1:0] hit;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic [RANK_W-1:0]  hit_rank;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   lru_idx;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               has_room;

    logic               do_touch;
    logic               do_insert;
    logic               do_remove;
    logic               wr_key;
    logic               wr_value;
    logic [IDX_W-1:0]   tgt_idx;
    logic [CNT_W-1:0]   ref_rank;

    // Keys are unique among valid entries, so the hit vector is one-hot or zero and the
    // index and rank can be formed by OR. Ranks of valid entries are always a permutation
    // of 0 .. used-1, so the least recent entry is the one whose rank equals used-1.
    always_comb begin
        hit      = '0;
        hit_idx  = '0;
        hit_rank = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit[i] = r_valid[i] && (r_key[i] == i_req.key);
            if (hit[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (r_valid[i] && (CNT_W'(r_rank[i]) == (r_used - CNT_W'(1)))) begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign found = |hit;

    // A capacity of zero acts as one; any capacity above the entry count acts as the entry count.
    always_comb begin
        cap_ext = CMP_W'(i_capacity);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign has_room = CMP_W'(r_used) < cap_eff;

    // Touch ages every valid entry more recent than the reference rank. An insert uses the
    // count in use as reference, so every valid entry ages. An eviction reuses the least
    // recent slot as a touch.
    always_comb begin
        do_touch  = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        wr_key    = 1'b0;
        wr_value  = 1'b0;
        tgt_idx   = hit_idx;
        ref_rank  = CNT_W'(hit_rank);
        unique case (i_req.op)
            OP_ADD: begin
                wr_value = 1'b1;
                if (found) begin
                    do_touch = 1'b1;
                end else if (has_room) begin
                    do_insert = 1'b1;
                    wr_key    = 1'b1;
                    tgt_idx   = free_idx;
                    ref_rank  = r_used;
                end else begin
                    do_touch = 1'b1;
                    wr_key   = 1'b1;
                    tgt_idx  = lru_idx;
                    ref_rank = r_used - CNT_W'(1);
                end
            end
            OP_GET: begin
                do_touch = found;
            end
            OP_ERASE: begin
                do_remove = found;
            end
            OP_CONTAINS: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_used  = r_used;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && (IDX_W'(i) != tgt_idx)) begin
                if ((do_touch || do_insert) && (CNT_W'(r_rank[i]) < ref_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
                if (do_remove && (CNT_W'(r_rank[i]) > ref_rank)) begin
                    n_rank[i] = r_rank[i] - RANK_W'(1);
                end
            end
        end
        if (do_touch || do_insert || do_remove) begin
            n_rank[tgt_idx] = '0;
        end
        if (do_insert) begin
            n_valid[tgt_idx] = 1'b1;
            n_used           = r_used + CNT_W'(1);
        end
        if (do_remove) begin
            n_valid[tgt_idx] = 1'b0;
            n_used           = r_used - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_fire) begin
            r_valid <= n_valid;
            r_used  <= n_used;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_key) begin
            r_key[tgt_idx] <= i_req.key;
        end
        if (i_fire && wr_value) begin
            r_value[tgt_idx] <= i_req.value;
        end
    end

    assign o_rsp.found      = found;
    assign o_rsp.status     = (i_req.op == OP_GET) && !found;
    assign o_rsp.read_value = ((i_req.op == OP_GET) && found) ? r_value[hit_idx] : '0;

endmodule

FILE: rtl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: stream ports, APB register and pipeline registers.
//
//  Channel   Dir  Handshake                Payload
//  -------   ---  -----------------------  ----------------------------------------------
//  request   in   i_s_tvalid / o_s_tready  tuser: operation; tdata: key, value
//  response  out  o_m_tvalid / i_m_tready  tuser: found, status; tdata: read_value
//  config    in   psel/penable/pwrite      capacity_in_use at byte address 0
//
// One word is accepted per cycle unless the input stalls. The accepting edge loads the
// request register; when nothing stalls, the core's result then loads the response
// register, which presents the response word. The two registers stand on either side
// of the combinational match and rank-update logic over all sixteen entries.
// A stalled response register holds the request register, and the input stalls only when
// both are full. Reset clears every valid bit, the count in use and all recency ranks, and
// sets the capacity to sixteen; the cache is usable directly after reset is released.
module lru_key_value_cache_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [63:0]                         i_s_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]                          i_s_tuser,   // operation [1:0]
    // Response stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [31:0]                         o_m_tdata,   // read_value [31:0]
    output logic [1:0]                          o_m_tuser,   // found [0], status [1]
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lkvc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lkvc_pkg::*;

    logic                 r_in_valid;
    t_req                 r_req;
    logic                 r_out_valid;
    t_rsp                 r_rsp;
    t_rsp                 core_rsp;
    logic [CAP_W-1:0]     r_capacity;
    logic                 proc_fire;
    logic                 in_accept;
    logic [REG_IDX_W-1:0] reg_idx;

    // The request register advances whenever the response register is empty or is being
    // drained in this cycle.
    assign proc_fire  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || proc_fire;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.op    <= t_op'(i_s_tuser);
            r_req.key   <= i_s_tdata[KEY_W-1:0];
            r_req.value <= i_s_tdata[KEY_W+VALUE_W-1:KEY_W];
        end
    end

    lkvc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (proc_fire),
        .i_req      (r_req),
        .i_capacity (r_capacity),
        .o_rsp      (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_rsp.read_value;
    assign o_m_tuser[0] = r_rsp.found;
    assign o_m_tuser[1] = r_rsp.status;

    // The register index is the word address; the low two byte-address bits are ignored.
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_CAPACITY) ? APB_DATA_W'(r_capacity) : '0;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the LRU key-value cache: directed table, random traffic, scoreboard.
module testbench;
    import lkvc_pkg::*;

    // Generous cycle budget for a correct run.
    localparam int CYCLE_LIMIT = 100000;
    // Byte address of the capacity register on the configuration port.
    localparam logic [APB_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    // Requests per random phase; nine phases give roughly 1550 words.
    localparam int PHASE_WORDS = 172;
    localparam int PHASES      = 9;

    // One row of the directed table. A configuration row writes its value field to the
    // capacity register. A request row with a typed response is checked against that
    // response; any other row is checked against the predictor.
    typedef struct packed {
        logic               is_cfg;
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_rsp               rsp;
    } t_stim_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [63:0]           i_s_tdata  = '0;
    logic [1:0]            i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [31:0]           o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lru_key_value_cache_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // key [31:0], value [63:32]
        .i_s_tuser  (i_s_tuser),   // operation [1:0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // read_value [31:0]
        .o_m_tuser  (o_m_tuser),   // found [0], status [1]
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the cache contents, kept in step with every accepted request word.
    logic [KEY_W-1:0]   shadow_keys  [ENTRIES];
    logic [VALUE_W-1:0] shadow_values[ENTRIES];
    logic               shadow_valid [ENTRIES];
    logic [RANK_W-1:0]  shadow_rank  [ENTRIES];
    logic [CNT_W-1:0]   shadow_used;
    logic [CAP_W-1:0]   shadow_capacity;

    // Responses predicted for accepted requests, oldest first.
    t_rsp expected_responses[$];

    int   mismatch_count = 0;
    int   response_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 37;
    int   recv_idle_pct  = 45;
    t_rsp seen_rsp;
    t_rsp want_rsp;

    t_stim_row directed_rows [27] = '{
        // Empty cache right after reset: nothing is found, a get reports not found.
        '{1'b0, OP_GET,      32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 32'h0}},
        '{1'b0, OP_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0}},
        '{1'b0, OP_ERASE,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0}},
        // Extreme keys and values.
        '{1'b0, OP_ADD,      32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0}},
        '{1'b0, OP_ADD,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0}},
        '{1'b0, OP_GET,      32'h0000_0000, 32'h0000_0000, 1'b1,
          '{1'b1, 1'b0, 32'hFFFF_FFFF}},
        '{1'b0, OP_GET,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 32'h0}},
        // Update of a present key, then presence and removal.
        '{1'b0, OP_ADD,      32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{1'b1, 1'b0, 32'h0}},
        '{1'b0, OP_CONTAINS, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0}},
        '{1'b0, OP_ERASE,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0}},
        '{1'b0, OP_GET,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 32'h0}},
        // Fill to four entries, then lower the capacity below the count held.
        '{1'b0, OP_ADD,      32'hA5A5_A5A5, 32'h1234_5678, 1'b0, '0},
        '{1'b0, OP_ADD,      32'h0000_FFFF, 32'hFFFF_0000, 1'b0, '0},
        '{1'b0, OP_ADD,      32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
        '{1'b1, OP_ADD,      32'h0000_0000, 32'd2,         1'b0, '0},
        // A new key now evicts the least recent entry and reuses its slot.
        '{1'b0, OP_ADD,      32'h1357_9BDF, 32'h2468_ACE0, 1'b0, '0},
        '{1'b0, OP_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{1'b0, OP_GET,      32'hA5A5_A5A5, 32'h0000_0000, 1'b0, '0},
        '{1'b0, OP_ERASE,    32'h0000_FFFF, 32'h0000_0000, 1'b0, '0},
        '{1'b0, OP_ERASE,    32'hFFFF_0000, 32'h0000_0000, 1'b0, '0},
        '{1'b0, OP_ADD,      32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        // A capacity of zero behaves as one.
        '{1'b1, OP_ADD,      32'h0000_0000, 32'd0,         1'b0, '0},
        '{1'b0, OP_ADD,      32'h0000_0001, 32'h8000_0000, 1'b0, '0},
        '{1'b0, OP_GET,      32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        // A capacity above the entry count behaves as the entry count.
        '{1'b1, OP_ADD,      32'h0000_0000, 32'd31,        1'b0, '0},
        '{1'b0, OP_CONTAINS, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
        '{1'b0, OP_GET,      32'h0000_0001, 32'h0000_0000, 1'b0, '0}
    };

    // Capacity written at the start of each random phase, extremes included.
    int phase_caps [PHASES] = '{4, 1, 16, 0, 31, 7, 2, 12, 16};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Capacity as the cache applies it: zero acts as one, anything above ENTRIES as ENTRIES.
    function automatic int effective_capacity();
        int c;
        c = int'(shadow_capacity);
        if (c == 0) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    // Make slot s the most recent; every valid slot that was more recent ages by one.
    function automatic void promote_slot(int s);
        logic [RANK_W-1:0] r;
        r = shadow_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
        shadow_rank[s] = '0;
    endfunction

    // Apply one request to the shadow cache and return the response it must produce.
    function automatic t_rsp cache_response(t_op op, logic [KEY_W-1:0] key,
                                            logic [VALUE_W-1:0] value);
        int                hit;
        int                slot;
        logic [RANK_W-1:0] r;
        t_rsp              rsp;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && shadow_valid[i] && shadow_keys[i] == key) hit = i;
        rsp       = '0;
        rsp.found = (hit >= 0);
        case (op)
            OP_ADD: begin
                if (hit >= 0) begin
                    shadow_values[hit] = value;
                    promote_slot(hit);
                end else begin
                    slot = -1;
                    if (int'(shadow_used) < effective_capacity())
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot < 0 && !shadow_valid[i]) slot = i;
                    if (slot < 0) begin
                        // Full at the capacity: the least recent entry gives up its slot.
                        for (int i = 0; i < ENTRIES; i++)
                            if (shadow_valid[i] &&
                                (slot < 0 || shadow_rank[i] > shadow_rank[slot])) slot = i;
                        if (slot < 0) slot = 0;
                    end
                    if (shadow_valid[slot]) begin
                        promote_slot(slot);
                    end else begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (shadow_valid[i]) shadow_rank[i]++;
                        shadow_valid[slot] = 1'b1;
                        shadow_rank[slot]  = '0;
                        shadow_used++;
                    end
                    shadow_keys[slot]   = key;
                    shadow_values[slot] = value;
                end
            end
            OP_GET: begin
                if (hit >= 0) begin
                    rsp.read_value = shadow_values[hit];
                    promote_slot(hit);
                end else begin
                    rsp.status = 1'b1;
                end
            end
            OP_ERASE: begin
                if (hit >= 0) begin
                    r = shadow_rank[hit];
                    for (int i = 0; i < ENTRIES; i++)
                        if (shadow_valid[i] && i != hit && shadow_rank[i] > r)
                            shadow_rank[i]--;
                    shadow_valid[hit] = 1'b0;
                    shadow_rank[hit]  = '0;
                    if (shadow_used != 0) shadow_used--;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at response %0d: %s got %h expected %h",
                 response_count, what, got, want);
        mismatch_count++;
    endtask

    // Offer one request word after a random gap, hold it until accepted, then record
    // the response it must produce. The valid stays high on return, so back-to-back
    // words never lower and raise it within one time step.
    task automatic send_request(t_op op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                                logic typed, t_rsp typed_rsp);
        t_rsp predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {value, key};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = cache_response(op, key, value);
        expected_responses.push_back(typed ? typed_rsp : predicted);
    endtask

    // Stop offering words and wait until every outstanding response has come back.
    task automatic drain_responses();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
    endtask

    // Write the capacity register while the cache is idle, then read it back. The upper
    // data bits carry random junk that the register must drop.
    task automatic write_capacity(logic [31:0] cap_word);
        logic [APB_DATA_W-1:0] readback;
        drain_responses();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= ($urandom() << CAP_W) | APB_DATA_W'(cap_word[CAP_W-1:0]);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_capacity = cap_word[CAP_W-1:0];
        // The read setup phase follows the write access directly.
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        if (readback[CAP_W-1:0] !== shadow_capacity)
            report_mismatch("capacity readback", 32'(readback[CAP_W-1:0]),
                            32'(shadow_capacity));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The receiver stalls at random, at the rate of the current idling mode.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every accepted response word is compared, field by field, with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_rsp.found      = o_m_tuser[0];
            seen_rsp.status     = o_m_tuser[1];
            seen_rsp.read_value = o_m_tdata;
            if (expected_responses.size() == 0) begin
                report_mismatch("response with none pending", 32'(seen_rsp), 32'h0);
            end else begin
                want_rsp = expected_responses.pop_front();
                if (seen_rsp.found !== want_rsp.found)
                    report_mismatch("found", 32'(seen_rsp.found), 32'(want_rsp.found));
                if (seen_rsp.status !== want_rsp.status)
                    report_mismatch("status", 32'(seen_rsp.status), 32'(want_rsp.status));
                if (seen_rsp.read_value !== want_rsp.read_value)
                    report_mismatch("read_value", seen_rsp.read_value, want_rsp.read_value);
            end
            response_count++;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** lru_key_value_cache_top: FAILED **");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key_pool[$];
        t_op                op;
        int                 r;
        int                 pool_size;

        for (int i = 0; i < ENTRIES; i++) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
            shadow_valid[i]  = 1'b0;
            shadow_rank[i]   = '0;
        end
        shadow_used     = '0;
        shadow_capacity = CAP_RESET;

        // Synchronous reset held from the start, released on a falling edge.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, with the sender and receiver both idling at the first rates.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_capacity(directed_rows[i].value);
            else
                send_request(directed_rows[i].op, directed_rows[i].key,
                             directed_rows[i].value, directed_rows[i].typed,
                             directed_rows[i].rsp);
        end

        // Random phases. Most requests draw keys from a small pool a little larger than
        // the capacity, so hits, updates, evictions and erases keep happening; about one
        // in ten uses a fresh random key as noise.
        for (int phase = 0; phase < PHASES; phase++) begin
            write_capacity(phase_caps[phase]);
            case (phase / 3)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            key_pool.delete();
            pool_size = effective_capacity() + $urandom_range(1, 8);
            for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom());
            for (int n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40)      op = OP_ADD;
                else if (r < 70) op = OP_GET;
                else if (r < 85) op = OP_ERASE;
                else             op = OP_CONTAINS;
                if ($urandom_range(0, 9) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                value = $urandom();
                send_request(op, key, value, 1'b0, '0);
            end
        end

        // Let every response come back, then keep watching for any stray word.
        drain_responses();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** lru_key_value_cache_top: PASSED **");
        else
            $display("** lru_key_value_cache_top: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lkvc_pkg.sv
rtl/lkvc_core.sv
rtl/lru_key_value_cache_top.sv
sim/testbench.sv
